// ===== rtl/core/roc_pkg.sv =====
// ----------------------------------------------------------------------------
// roc_pkg: shared types and constants for the RGBA source-over compositor
// Pixel layout, the record that flows through the divider stages, and the
// fixed widths of the blend arithmetic.
// ----------------------------------------------------------------------------
package roc_pkg;

	localparam int unsigned CHAN_W   = 8;                  // one colour or alpha channel
	localparam int unsigned WEIGHT_W = 16;                 // combined weight, up to 65025
	localparam int unsigned NUM_W    = 24;                 // channel numerator, up to 255*65025
	localparam int unsigned NCHAN    = 3;                  // red, green, blue
	localparam int unsigned DIV_BITS = 2;                  // quotient bits resolved per stage
	localparam int unsigned NDIV     = CHAN_W / DIV_BITS;  // divider stages
	localparam logic [CHAN_W-1:0] FULL_SCALE = 8'd255;

	// Input pixel pair, back_red in the lowest bits
	typedef struct packed {
		logic [CHAN_W-1:0] fore_alpha;
		logic [CHAN_W-1:0] fore_blue;
		logic [CHAN_W-1:0] fore_green;
		logic [CHAN_W-1:0] fore_red;
		logic [CHAN_W-1:0] back_alpha;
		logic [CHAN_W-1:0] back_blue;
		logic [CHAN_W-1:0] back_green;
		logic [CHAN_W-1:0] back_red;
	} pixel_t;

	// Composited pixel, out_red in the lowest bits
	typedef struct packed {
		logic [CHAN_W-1:0] out_alpha;
		logic [CHAN_W-1:0] out_blue;
		logic [CHAN_W-1:0] out_green;
		logic [CHAN_W-1:0] out_red;
	} result_t;

	// Record carried through the restoring divider; index 0 is red
	typedef struct packed {
		logic [NCHAN-1:0][NUM_W-1:0]  rem;
		logic [NCHAN-1:0][CHAN_W-1:0] quo;
		logic [WEIGHT_W-1:0]          total;
		logic [CHAN_W-1:0]            alpha;
		logic                         zero;
	} div_t;

endpackage

// ===== rtl/core/roc_weight.sv =====
// ----------------------------------------------------------------------------
// roc_weight: weight and numerator stages of the compositor
// Stage 1 forms the foreground and background weights and their sum; stage 2
// forms the three channel numerators and the output alpha.
// ----------------------------------------------------------------------------
module roc_weight (
	input  logic            clk,
	input  logic            en_s1,
	input  logic            en_s2,
	input  roc_pkg::pixel_t pix,
	output roc_pkg::div_t   div_s2
);

	roc_pkg::pixel_t                   pix_s1;
	logic [roc_pkg::WEIGHT_W-1:0]      fore_w_s1;
	logic [roc_pkg::WEIGHT_W-1:0]      back_w_s1;
	logic [roc_pkg::WEIGHT_W-1:0]      total_s1;

	logic [roc_pkg::WEIGHT_W-1:0]      fore_w;
	logic [roc_pkg::WEIGHT_W-1:0]      back_w;
	logic [roc_pkg::WEIGHT_W-1:0]      alpha_sum;
	logic [roc_pkg::NCHAN-1:0][roc_pkg::CHAN_W-1:0] fore_c;
	logic [roc_pkg::NCHAN-1:0][roc_pkg::CHAN_W-1:0] back_c;
	roc_pkg::div_t                     div_d;

	// Weights: fore = fa*255, back = (255-fa)*ba
	always_comb begin
		fore_w = {pix.fore_alpha, 8'd0} - {8'd0, pix.fore_alpha};
		back_w = {8'd0, roc_pkg::FULL_SCALE - pix.fore_alpha} * {8'd0, pix.back_alpha};
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			pix_s1    <= pix;
			fore_w_s1 <= fore_w;
			back_w_s1 <= back_w;
			total_s1  <= fore_w + back_w;
		end
	end

	// Numerators per channel, and alpha = floor(total/255) for totals up to 65025
	always_comb begin
		fore_c = {pix_s1.fore_blue, pix_s1.fore_green, pix_s1.fore_red};
		back_c = {pix_s1.back_blue, pix_s1.back_green, pix_s1.back_red};
		alpha_sum = total_s1 + 16'd1 + {8'd0, total_s1[15:8]};
		div_d.quo   = '0;
		div_d.total = total_s1;
		div_d.alpha = alpha_sum[15:8];
		div_d.zero  = (total_s1 == '0);
		for (int c = 0; c < roc_pkg::NCHAN; c++) begin
			div_d.rem[c] = ({8'd0, fore_w_s1} * {16'd0, fore_c[c]})
				+ ({8'd0, back_w_s1} * {16'd0, back_c[c]});
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			div_s2 <= div_d;
		end
	end

endmodule

// ===== rtl/core/roc_div_stage.sv =====
// ----------------------------------------------------------------------------
// roc_div_stage: one stage of the restoring channel divider
// Resolves two quotient bits, from BIT_HI down, for all three channels
// against the shared combined weight.
// ----------------------------------------------------------------------------
module roc_div_stage #(
	parameter int unsigned BIT_HI = 7
) (
	input  logic          clk,
	input  logic          en,
	input  roc_pkg::div_t din,
	output roc_pkg::div_t dout
);

	roc_pkg::div_t               nxt;
	logic [roc_pkg::NUM_W:0]     r;
	logic [roc_pkg::NUM_W:0]     d;
	logic [roc_pkg::NUM_W:0]     t;

	// Trial subtract of the shifted divisor, keep when no borrow
	always_comb begin
		nxt = din;
		r   = '0;
		d   = '0;
		t   = '0;
		for (int c = 0; c < roc_pkg::NCHAN; c++) begin
			r = {1'b0, din.rem[c]};
			for (int k = 0; k < roc_pkg::DIV_BITS; k++) begin
				d = {{(roc_pkg::NUM_W + 1 - roc_pkg::WEIGHT_W){1'b0}}, din.total}
					<< (BIT_HI - k);
				t = r - d;
				if (!t[roc_pkg::NUM_W]) begin
					r = t;
				end
				nxt.quo[c][BIT_HI-k] = !t[roc_pkg::NUM_W];
			end
			nxt.rem[c] = r[roc_pkg::NUM_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dout <= nxt;
		end
	end

endmodule

// ===== rtl/core/rgba_over_compositor.sv =====
// ----------------------------------------------------------------------------
// rgba_over_compositor: source-over blend of straight-alpha RGBA8 pixels
// Weight, numerator and four divider stages behind a valid/ready chain.
// ----------------------------------------------------------------------------
// The block takes one background/foreground pixel pair per clock while the
// output is not stalled, and passes each through a six-stage pipeline: a
// weight stage, a numerator stage, and four restoring divider stages that each
// resolve two quotient bits of all three colour channels. Each stage holds its
// item while the next one is full and stalled, and fills any bubble ahead of
// it, so a stall on the output loses or repeats nothing. When both alphas are
// zero every output is zero.
module rgba_over_compositor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// back_red, back_green, back_blue, back_alpha,
	// fore_red, fore_green, fore_blue, fore_alpha
	input  logic [63:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// out_red, out_green, out_blue, out_alpha
	output logic [31:0] m_tdata
);

	localparam int unsigned NSTAGE = 2 + roc_pkg::NDIV;

	logic [NSTAGE-1:0] valid_q;
	logic [NSTAGE:0]   ready;
	roc_pkg::div_t     div_d [roc_pkg::NDIV+1];
	roc_pkg::result_t  res;

	// Ready chain: a stage loads when empty or when its successor moves
	always_comb begin
		ready[NSTAGE] = m_tready;
		for (int i = NSTAGE - 1; i >= 0; i--) begin
			ready[i] = !valid_q[i] || ready[i+1];
		end
	end

	// Advance valid bits with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (ready[0]) begin
				valid_q[0] <= s_tvalid;
			end
			for (int i = 1; i < NSTAGE; i++) begin
				if (ready[i]) begin
					valid_q[i] <= valid_q[i-1];
				end
			end
		end
	end

	roc_weight u_weight (
		.clk    (clk),
		.en_s1  (ready[0]),
		.en_s2  (ready[1]),
		.pix    (roc_pkg::pixel_t'(s_tdata)),
		.div_s2 (div_d[0])
	);

	for (genvar g = 0; g < roc_pkg::NDIV; g++) begin : g_div
		roc_div_stage #(
			.BIT_HI (roc_pkg::CHAN_W - 1 - g * roc_pkg::DIV_BITS)
		) u_div (
			.clk  (clk),
			.en   (ready[2+g]),
			.din  (div_d[g]),
			.dout (div_d[g+1])
		);
	end

	// Drop the colour quotients when the combined weight is zero
	always_comb begin
		res.out_red   = div_d[roc_pkg::NDIV].zero ? '0 : div_d[roc_pkg::NDIV].quo[0];
		res.out_green = div_d[roc_pkg::NDIV].zero ? '0 : div_d[roc_pkg::NDIV].quo[1];
		res.out_blue  = div_d[roc_pkg::NDIV].zero ? '0 : div_d[roc_pkg::NDIV].quo[2];
		res.out_alpha = div_d[roc_pkg::NDIV].alpha;
	end

	assign s_tready = ready[0];
	assign m_tvalid = valid_q[NSTAGE-1];
	assign m_tdata  = res;

endmodule

// ===== rtl/core/roc_checker.sv =====
// ----------------------------------------------------------------------------
// roc_checker: port-level checks for the RGBA source-over compositor
// Watches the stream ports over time; bound to the top level below.
// ----------------------------------------------------------------------------
module roc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [63:0] s_tdata,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);

	// Hold a stalled output transaction
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output transaction changed while stalled");

	// Input side must be open whenever the output side can move
	a_in_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(!m_tvalid || m_tready) |-> s_tready)
		else $error("input stalled with a free pipeline");

	// A fully transparent result has no colour
	a_clear_black: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[31:24] == 8'd0) |-> (m_tdata[23:0] == 24'd0))
		else $error("transparent result carries colour");

	// No output transaction straight out of reset
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |=> !m_tvalid)
		else $error("output valid right after reset");

endmodule

bind rgba_over_compositor roc_checker u_roc_checker (.*);

// ===== bench/rgba_over_compositor_tb.sv =====
// ----------------------------------------------------------------------------
// rgba_over_compositor_tb: self-checking bench for the source-over compositor
// Walks a directed table of pixel pairs (both alphas zero, opaque and
// transparent layers, field extremes), then streams random pairs through
// phases of sender gaps, receiver stalls and one long output hold-off.
// Every output transaction is checked field by field against a hand-typed
// result or a local integer model of straight-alpha source-over.
// ----------------------------------------------------------------------------
module rgba_over_compositor_tb;

	localparam int unsigned RESET_CYCLES = 7;
	localparam int unsigned PIPE_DEPTH   = 6;
	localparam int unsigned DRAIN_CYCLES = 4 * PIPE_DEPTH;
	localparam int unsigned HOLD_CYCLES  = 64;
	localparam int unsigned QUIET_LIMIT  = 4000;
	localparam int unsigned N_DIRECTED   = 20;

	typedef enum logic [2:0] {
		PH_STEADY,
		PH_SEND_GAPS,
		PH_RECV_STALLS,
		PH_BOTH,
		PH_BACKPRESSURE
	} phase_e;

	// One directed row: known marks a hand-typed expected pixel
	typedef struct packed {
		logic             known;
		roc_pkg::result_t res;
		roc_pkg::pixel_t  px;
	} dir_row_t;

	// Pixel: fa fb fg fr _ ba bb bg br   Result: oa ob og or
	localparam dir_row_t DIR_TBL [N_DIRECTED] = '{
		'{1'b1, 32'h00000000, 64'h00000000_00000000},  // both alphas zero, black
		'{1'b1, 32'h00000000, 64'h00FFFFFF_00FFFFFF},  // both alphas zero, white
		'{1'b1, 32'h00000000, 64'h00563412_00BC9A78},  // both alphas zero, mixed
		'{1'b1, 32'hFF1E140A, 64'hFF1E140A_4D3264C8},  // opaque fore wins
		'{1'b1, 32'hFFFFFFFF, 64'hFFFFFFFF_FFFFFFFF},  // all ones
		'{1'b1, 32'hFF000000, 64'hFF000000_FFFFFFFF},  // opaque black on white
		'{1'b1, 32'hFF030201, 64'h00ABCDEF_FF030201},  // clear fore, opaque back
		'{1'b1, 32'h010780FF, 64'h00FFFFFF_010780FF},  // clear fore, faint back
		'{1'b1, 32'h80FF55AA, 64'h00123456_80FF55AA},  // clear fore, half back
		'{1'b1, 32'h018000FF, 64'h018000FF_00FFFFFF},  // faint fore, clear back
		'{1'b1, 32'h80070809, 64'h80070809_00AABBCC},  // half fore, clear back
		'{1'b0, 32'h00000000, 64'h01FFFFFF_FF000000},
		'{1'b0, 32'h00000000, 64'hFE000000_FFFFFFFF},
		'{1'b0, 32'h00000000, 64'h80FF0080_8000FF80},
		'{1'b0, 32'h00000000, 64'h7F55AA55_01AA55AA},
		'{1'b0, 32'h00000000, 64'h01000000_01FFFFFF},
		'{1'b0, 32'h00000000, 64'h55AA55AA_AA55AA55},
		'{1'b0, 32'h00000000, 64'hAA55AA55_55AA55AA},
		'{1'b0, 32'h00000000, 64'h7F808080_FF7F7F7F},
		'{1'b0, 32'h00000000, 64'h40C0C0C0_C0404040}
	};

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata  = '0;     // back r,g,b,a then fore r,g,b,a from bit 0
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;           // out r,g,b,a from bit 0

	phase_e           phase = PH_STEADY;
	roc_pkg::result_t expected_pixels [$];
	int unsigned mismatch_cnt   = 0;
	int unsigned pairs_sent     = 0;
	int unsigned pixels_checked = 0;
	int unsigned clear_pairs    = 0;
	int unsigned in_stall_cyc   = 0;
	int unsigned hold_left      = 0;
	bit          hold_done      = 1'b0;

	always #1 clk = ~clk;

	rgba_over_compositor u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// Weighted blend of one colour channel, truncated
	function automatic logic [7:0] blend_chan(int unsigned back_c, int unsigned fore_c,
			int unsigned back_w, int unsigned fore_w, int unsigned total);
		int unsigned num;
		int unsigned q;
		num = fore_w * fore_c + back_w * back_c;
		if (total == 0)
			return 8'd0;
		q = num / total;
		if (q > 255)
			q = 255;
		return q[7:0];
	endfunction

	// Straight-alpha source-over of the fore pixel onto the back pixel
	function automatic roc_pkg::result_t source_over(roc_pkg::pixel_t px);
		int unsigned      fa;
		int unsigned      ba;
		int unsigned      fore_w;
		int unsigned      back_w;
		int unsigned      total;
		int unsigned      alpha;
		roc_pkg::result_t r;
		fa     = px.fore_alpha;
		ba     = px.back_alpha;
		fore_w = fa * 255;
		back_w = (255 - fa) * ba;
		total  = fore_w + back_w;
		alpha  = total / 255;
		r.out_red   = blend_chan(px.back_red, px.fore_red, back_w, fore_w, total);
		r.out_green = blend_chan(px.back_green, px.fore_green, back_w, fore_w, total);
		r.out_blue  = blend_chan(px.back_blue, px.fore_blue, back_w, fore_w, total);
		r.out_alpha = alpha[7:0];
		return r;
	endfunction

	// Random pair, with alphas pulled toward the corners now and then
	function automatic roc_pkg::pixel_t random_pixel();
		roc_pkg::pixel_t px;
		px = {$urandom, $urandom};
		case ($urandom_range(9))
			6: px.fore_alpha = 8'd0;
			7: px.fore_alpha = roc_pkg::FULL_SCALE;
			8: px.back_alpha = 8'd0;
			9: begin
				px.fore_alpha = 8'($urandom_range(3));
				px.back_alpha = 8'($urandom_range(3));
			end
			default: ;
		endcase
		return px;
	endfunction

	function automatic int unsigned send_gap_pct(phase_e ph);
		case (ph)
			PH_SEND_GAPS: return 46;
			PH_BOTH:      return 16;
			default:      return 0;
		endcase
	endfunction

	function automatic int unsigned recv_stall_pct(phase_e ph);
		case (ph)
			PH_RECV_STALLS:  return 46;
			PH_BOTH:         return 16;
			PH_BACKPRESSURE: return 16;
			default:         return 0;
		endcase
	endfunction

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %02h, got %02h", $time, name, want, got);
			mismatch_cnt++;
		end
	endtask

	// Offer one pixel pair, wait for its transaction, queue its composite
	task automatic drive_pixel(input roc_pkg::pixel_t px, input logic known,
			input roc_pkg::result_t res);
		while ($urandom_range(99) < send_gap_pct(phase)) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= px;
		do begin
			@(posedge clk);
			if (!s_tready)
				in_stall_cyc++;
		end while (!s_tready);
		expected_pixels.push_back(known ? res : source_over(px));
		pairs_sent++;
		if (px.fore_alpha == 0 && px.back_alpha == 0)
			clear_pairs++;
	endtask

	task automatic run_random(input phase_e ph, input int unsigned count);
		phase = ph;
		repeat (count)
			drive_pixel(random_pixel(), 1'b0, '0);
	endtask

	// Check output transactions and pick the receiver readiness for next cycle
	always @(posedge clk) begin : pixel_check
		roc_pkg::result_t got;
		roc_pkg::result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (expected_pixels.size() == 0) begin
				$display("%0t: result %08h with no pixel pair outstanding", $time, got);
				mismatch_cnt++;
			end else begin
				want = expected_pixels.pop_front();
				check_field("out_red", want.out_red, got.out_red);
				check_field("out_green", want.out_green, got.out_green);
				check_field("out_blue", want.out_blue, got.out_blue);
				check_field("out_alpha", want.out_alpha, got.out_alpha);
				pixels_checked++;
			end
		end
		// hold off once for a long stretch so the pipeline fills and stalls its input
		if (phase == PH_BACKPRESSURE && !hold_done) begin
			hold_left = HOLD_CYCLES;
			hold_done = 1'b1;
		end
		if (hold_left != 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct(phase));
		end
	end

	// End the run when no transaction moves for too long
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
		$display("end of test: mismatches");
		$finish;
	end

	initial begin : stimulus
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, back to back
		phase = PH_STEADY;
		foreach (DIR_TBL[i])
			drive_pixel(DIR_TBL[i].px, DIR_TBL[i].known, DIR_TBL[i].res);

		run_random(PH_STEADY, 300);
		run_random(PH_SEND_GAPS, 350);
		run_random(PH_RECV_STALLS, 350);
		run_random(PH_BOTH, 350);
		run_random(PH_BACKPRESSURE, 150);
		run_random(PH_STEADY, 200);

		// drain the pipeline
		s_tvalid <= 1'b0;
		phase = PH_STEADY;
		while (expected_pixels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Composited %0d pixel pairs (%0d with both alphas zero), %0d results checked.",
			pairs_sent, clear_pairs, pixels_checked);
		$display("Covered sender gaps, receiver stalls, and a %0d-cycle hold with %0d input stalls.",
			HOLD_CYCLES, in_stall_cyc);
		if (mismatch_cnt == 0 && expected_pixels.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
